/* rtl/llae_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llae_pkg: shared types and constants of the life-like automaton engine
// Grid geometry, transaction payloads, request and register codes, and the
// sequencer state encoding.
// ----------------------------------------------------------------------------
package llae_pkg;

	// Grid geometry: coordinates are fixed 8-bit fields
	localparam int COL_BITS   = 8;
	localparam int ROW_BITS   = 8;
	localparam int MAX_WIDTH  = 1 << COL_BITS;
	localparam int MAX_HEIGHT = 1 << ROW_BITS;
	localparam int ADDR_BITS  = COL_BITS + ROW_BITS;
	localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
	localparam int SIZE_BITS  = 9;
	localparam int SIZE_MIN   = 3;

	localparam int AGE_BITS   = 16;
	localparam int POP_BITS   = 17;
	localparam int GEN_BITS   = 32;
	localparam int MASK_BITS  = 9;
	localparam int NBR_BITS   = 4;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;

	localparam int Q_DEPTH    = 2;
	localparam int Q_PTR_BITS = 1;

	localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_READ  = 2'd1,
		REQ_STEP  = 2'd2,
		REQ_CLEAR = 2'd3
	} req_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_SURVIVAL = 3'd0,
		CFG_BIRTH    = 3'd1,
		CFG_LIFE     = 3'd2,
		CFG_WIDTH    = 3'd3,
		CFG_HEIGHT   = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		req_t                req_type;
		logic [COL_BITS-1:0] col;
		logic [ROW_BITS-1:0] row;
		logic                alive_in;
	} in_item_t;

	typedef struct packed {
		logic                alive_out;
		logic [AGE_BITS-1:0] age;
		logic [POP_BITS-1:0] live_count;
		logic [GEN_BITS-1:0] gen_count;
		logic                status;
	} out_item_t;

	// Live configuration, sizes already limited to the usable range
	typedef struct packed {
		logic [MASK_BITS-1:0] survival_mask;
		logic [MASK_BITS-1:0] birth_mask;
		logic [AGE_BITS-1:0]  life_time;
		logic [SIZE_BITS-1:0] width;
		logic [SIZE_BITS-1:0] height;
	} cfg_t;

	// Classified request handed from the front to the back
	typedef struct packed {
		req_t                req;
		logic [COL_BITS-1:0] col;
		logic [ROW_BITS-1:0] row;
		logic                alive;
		logic                oob;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_ACCESS,
		ST_UPDATE,
		ST_CLEAR,
		ST_ZERO,
		ST_FETCH,
		ST_DRAIN,
		ST_RESP
	} state_t;

endpackage

/* rtl/llae_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llae_front: configuration registers and request classification
// Holds the rule and grid registers, accepts requests and flags coordinates
// outside the configured grid before queuing them for the back end.
// ----------------------------------------------------------------------------
module llae_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [llae_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [llae_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  llae_pkg::in_item_t                  in_data,
	input  logic                                init_busy,
	input  logic                                q_full,
	output logic                                push,
	output llae_pkg::cmd_t                      push_cmd,
	output llae_pkg::cfg_t                      cfg
);
	import llae_pkg::*;

	logic [MASK_BITS-1:0] survival_q;
	logic [MASK_BITS-1:0] birth_q;
	logic [AGE_BITS-1:0]  life_q;
	logic [SIZE_BITS-1:0] width_q;
	logic [SIZE_BITS-1:0] height_q;

	// Limit a size register to the range the grid supports
	function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] v,
			input logic [SIZE_BITS-1:0] maxv);
		logic [SIZE_BITS-1:0] r;
		if (v < SIZE_BITS'(SIZE_MIN)) begin
			r = SIZE_BITS'(SIZE_MIN);
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			survival_q <= MASK_BITS'(12);
			birth_q    <= MASK_BITS'(8);
			life_q     <= '0;
			width_q    <= SIZE_BITS'(64);
			height_q   <= SIZE_BITS'(64);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SURVIVAL: survival_q <= cfg_data[MASK_BITS-1:0];
				CFG_BIRTH:    birth_q    <= cfg_data[MASK_BITS-1:0];
				CFG_LIFE:     life_q     <= cfg_data[AGE_BITS-1:0];
				CFG_WIDTH:    width_q    <= cfg_data[SIZE_BITS-1:0];
				CFG_HEIGHT:   height_q   <= cfg_data[SIZE_BITS-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		cfg.survival_mask = survival_q;
		cfg.birth_mask    = birth_q;
		cfg.life_time     = life_q;
		cfg.width         = eff_size(width_q, SIZE_BITS'(MAX_WIDTH));
		cfg.height        = eff_size(height_q, SIZE_BITS'(MAX_HEIGHT));
	end

	// Classify the request and flag cell accesses outside the grid
	always_comb begin
		push_cmd.req   = in_data.req_type;
		push_cmd.col   = in_data.col;
		push_cmd.row   = in_data.row;
		push_cmd.alive = in_data.alive_in;
		push_cmd.oob   = ((in_data.req_type == REQ_WRITE) || (in_data.req_type == REQ_READ))
			&& (({1'b0, in_data.col} >= cfg.width) || ({1'b0, in_data.row} >= cfg.height));
	end

	assign in_ready = !q_full && !init_busy;
	assign push     = in_valid && in_ready;

endmodule

/* rtl/llae_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llae_queue: short command queue between front and back
// Two-entry FIFO that lets the front take requests while the back works.
// ----------------------------------------------------------------------------
module llae_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  llae_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output llae_pkg::cmd_t pop_cmd
);
	import llae_pkg::*;

	cmd_t                  entry_q [Q_DEPTH];
	logic [Q_PTR_BITS-1:0] wptr_q;
	logic [Q_PTR_BITS-1:0] rptr_q;
	logic [Q_PTR_BITS:0]   count_q;

	assign full    = (count_q == (Q_PTR_BITS+1)'(Q_DEPTH));
	assign valid   = (count_q != '0);
	assign pop_cmd = entry_q[rptr_q];

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/llae_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llae_back: cell store and request sequencer
// Two age banks, the generation sweep with a sliding 3x3 window, clearing
// passes, population and generation counters, and the result register.
// ----------------------------------------------------------------------------
module llae_back (
	input  logic                clk,
	input  logic                arst_n,
	input  llae_pkg::cfg_t      cfg,
	input  logic                q_valid,
	input  llae_pkg::cmd_t      q_cmd,
	output logic                pop,
	output logic                init_busy,
	output logic                out_valid,
	input  logic                out_ready,
	output llae_pkg::out_item_t out_data
);
	import llae_pkg::*;

	state_t state_q, state_d;

	logic [AGE_BITS-1:0] bank_a_q [CELLS];
	logic [AGE_BITS-1:0] bank_b_q [CELLS];
	logic [AGE_BITS-1:0] rdata_a_s1, rdata_b_s1;
	logic [AGE_BITS-1:0] cur_data;

	logic [ADDR_BITS-1:0] ra, wa;
	logic [AGE_BITS-1:0]  wd;
	logic                 we_a, we_b, we_next;

	cmd_t                 cmd_q;
	logic [AGE_BITS-1:0]  res_age_q;
	logic [ADDR_BITS-1:0] sweep_q;
	logic                 sweep_last;

	logic [ROW_BITS-1:0]  row_q;
	logic [SIZE_BITS-1:0] k_q;
	logic [1:0]           p_q;
	logic [COL_BITS-1:0]  tcol_q;
	logic                 fetch_last, row_last;
	logic [ROW_BITS-1:0]  row_up, row_dn, row_sel;
	logic [COL_BITS-1:0]  fcol;

	logic                 rd_valid_s1;
	logic [1:0]           rd_phase_s1;
	logic                 rd_live_s1;

	logic                 colt_q;
	logic [AGE_BITS-1:0]  colm_age_q;
	logic [2:0]           wc_q, wr_q, new_col;
	logic [AGE_BITS-1:0]  wr_age_q;
	logic [NBR_BITS-1:0]  nbr;
	logic [AGE_BITS-1:0]  new_age;
	logic                 cell_done;
	logic                 survive;

	logic                 bank_sel_q;
	logic [POP_BITS-1:0]  pop_q, pop_acc_q, pop_acc_d;
	logic [GEN_BITS-1:0]  gen_q;

	out_item_t            out_q;
	logic                 out_valid_q;
	logic                 resp_take;

	assign cur_data   = bank_sel_q ? rdata_b_s1 : rdata_a_s1;
	assign sweep_last = &sweep_q;
	assign init_busy  = (state_q == ST_INIT);
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;
	assign resp_take  = (state_q == ST_RESP) && (!out_valid_q || out_ready);

	// Neighbor rows and fetch column with wrap at the grid edges
	assign row_up = (row_q == '0) ? ROW_BITS'(cfg.height - 1'b1) : row_q - 1'b1;
	assign row_dn = (({1'b0, row_q} + 1'b1) == cfg.height) ? '0 : row_q + 1'b1;
	assign row_last = (({1'b0, row_q} + 1'b1) == cfg.height);
	assign fetch_last = (k_q == cfg.width + 1'b1) && (p_q == 2'd2);

	always_comb begin
		if (k_q == '0) begin
			fcol = COL_BITS'(cfg.width - 1'b1);
		end else if (k_q == cfg.width + 1'b1) begin
			fcol = '0;
		end else begin
			fcol = COL_BITS'(k_q - 1'b1);
		end
		unique case (p_q)
			2'd0:    row_sel = row_up;
			2'd1:    row_sel = row_q;
			default: row_sel = row_dn;
		endcase
	end

	// Apply the rule to the window center as its right column arrives
	always_comb begin
		new_col   = {colt_q, colm_age_q != '0, cur_data != '0};
		cell_done = rd_valid_s1 && (rd_phase_s1 == 2'd2) && rd_live_s1;
		nbr = NBR_BITS'(wc_q[0]) + NBR_BITS'(wc_q[1]) + NBR_BITS'(wc_q[2])
			+ NBR_BITS'(wr_q[0]) + NBR_BITS'(wr_q[2])
			+ NBR_BITS'(new_col[0]) + NBR_BITS'(new_col[1]) + NBR_BITS'(new_col[2]);
		survive = cfg.survival_mask[nbr]
			&& ((cfg.life_time == '0) || (wr_age_q < cfg.life_time));
		new_age = '0;
		if (wr_age_q != '0) begin
			if (survive) begin
				new_age = (wr_age_q == AGE_MAX) ? AGE_MAX : wr_age_q + 1'b1;
			end
		end else if (cfg.birth_mask[nbr]) begin
			new_age = AGE_BITS'(1);
		end
		pop_acc_d = pop_acc_q + ((cell_done && (new_age != '0)) ? POP_BITS'(1) : '0);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT:   if (sweep_last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (q_valid) begin
					unique case (q_cmd.req)
						REQ_STEP:  state_d = ST_ZERO;
						REQ_CLEAR: state_d = ST_CLEAR;
						default:   state_d = q_cmd.oob ? ST_RESP : ST_ACCESS;
					endcase
				end
			end
			ST_ACCESS: state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_RESP;
			ST_CLEAR:  if (sweep_last) state_d = ST_RESP;
			ST_ZERO:   if (sweep_last) state_d = ST_FETCH;
			ST_FETCH:  if (fetch_last) state_d = ST_DRAIN;
			ST_DRAIN:  state_d = row_last ? ST_RESP : ST_FETCH;
			ST_RESP:   if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Memory port controls
	always_comb begin
		pop     = 1'b0;
		ra      = {cmd_q.row, cmd_q.col};
		wa      = sweep_q;
		wd      = '0;
		we_a    = 1'b0;
		we_b    = 1'b0;
		we_next = 1'b0;
		unique case (state_q)
			ST_INIT, ST_CLEAR: begin
				we_a = 1'b1;
				we_b = 1'b1;
			end
			ST_IDLE: pop = q_valid;
			ST_UPDATE: begin
				if (cmd_q.req == REQ_WRITE) begin
					wa   = {cmd_q.row, cmd_q.col};
					wd   = cmd_q.alive ? AGE_BITS'(1) : '0;
					we_a = !bank_sel_q;
					we_b = bank_sel_q;
				end
			end
			ST_ZERO: we_next = 1'b1;
			ST_FETCH, ST_DRAIN: begin
				ra = {row_sel, fcol};
				if (cell_done) begin
					wa      = {row_q, tcol_q};
					wd      = new_age;
					we_next = 1'b1;
				end
			end
			default: ;
		endcase
		if (we_next) begin
			we_a = bank_sel_q;
			we_b = !bank_sel_q;
		end
	end

	// Age banks with registered reads
	always_ff @(posedge clk) begin
		if (we_a) begin
			bank_a_q[wa] <= wd;
		end
		rdata_a_s1 <= bank_a_q[ra];
	end

	always_ff @(posedge clk) begin
		if (we_b) begin
			bank_b_q[wa] <= wd;
		end
		rdata_b_s1 <= bank_b_q[ra];
	end

	// Hold the command and the window, which need no reset
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q     <= q_cmd;
			res_age_q <= '0;
		end
		if ((state_q == ST_UPDATE) && (cmd_q.req == REQ_READ)) begin
			res_age_q <= cur_data;
		end
		if (rd_valid_s1) begin
			unique case (rd_phase_s1)
				2'd0: colt_q     <= (cur_data != '0);
				2'd1: colm_age_q <= cur_data;
				default: begin
					wc_q     <= wr_q;
					wr_q     <= new_col;
					wr_age_q <= colm_age_q;
				end
			endcase
		end
		rd_phase_s1 <= p_q;
		rd_live_s1  <= (k_q >= SIZE_BITS'(2));
		if (resp_take) begin
			out_q.alive_out  <= (res_age_q != '0);
			out_q.age        <= res_age_q;
			out_q.live_count <= pop_q;
			out_q.gen_count  <= gen_q;
			out_q.status     <= cmd_q.oob;
		end
	end

	// Advance the sequencer and the counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			sweep_q     <= '0;
			row_q       <= '0;
			k_q         <= '0;
			p_q         <= '0;
			tcol_q      <= '0;
			rd_valid_s1 <= 1'b0;
			bank_sel_q  <= 1'b0;
			pop_q       <= '0;
			pop_acc_q   <= '0;
			gen_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= (state_q == ST_FETCH);
			if ((state_q == ST_INIT) || (state_q == ST_CLEAR) || (state_q == ST_ZERO)) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if ((state_q == ST_UPDATE) && (cmd_q.req == REQ_WRITE)) begin
				if ((cur_data == '0) && cmd_q.alive) begin
					pop_q <= pop_q + 1'b1;
				end else if ((cur_data != '0) && !cmd_q.alive) begin
					pop_q <= pop_q - 1'b1;
				end
			end
			if ((state_q == ST_CLEAR) && sweep_last) begin
				pop_q <= '0;
				gen_q <= '0;
			end
			if ((state_q == ST_ZERO) && sweep_last) begin
				row_q     <= '0;
				k_q       <= '0;
				p_q       <= '0;
				tcol_q    <= '0;
				pop_acc_q <= '0;
			end
			if (state_q == ST_FETCH) begin
				if (p_q == 2'd2) begin
					p_q <= '0;
					k_q <= k_q + 1'b1;
				end else begin
					p_q <= p_q + 1'b1;
				end
				if (cell_done) begin
					tcol_q <= tcol_q + 1'b1;
				end
			end
			if ((state_q == ST_FETCH) || (state_q == ST_DRAIN)) begin
				pop_acc_q <= pop_acc_d;
			end
			if (state_q == ST_DRAIN) begin
				k_q    <= '0;
				p_q    <= '0;
				tcol_q <= '0;
				if (row_last) begin
					bank_sel_q <= !bank_sel_q;
					pop_q      <= pop_acc_d;
					gen_q      <= gen_q + 1'b1;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end
			if (resp_take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/life_like_automaton_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_like_automaton_engine: life-like cellular automaton on a torus
// Cell ages in two banks; requests write, read, step or clear the grid.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------
//   cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//   in      | in        | in_valid/in_ready    | in_data (in_item_t)
//   out     | out       | out_valid/out_ready  | out_data (out_item_t)
//
// Write and read pass through queue pop, bank read, update and result.
// Clear sweeps every cell of both banks, one cell a cycle.
// Step runs a zeroing pass of the target bank, then three single-port
// reads per fetched window column.
// After reset a clearing pass runs with in_ready low.
// A two-entry queue takes requests while a result waits in the output register.
// ----------------------------------------------------------------------------
module life_like_automaton_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [llae_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [llae_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  llae_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output llae_pkg::out_item_t                 out_data
);
	import llae_pkg::*;

	cfg_t cfg;
	cmd_t push_cmd, q_cmd;
	logic push, q_full, q_valid, pop, init_busy;

	llae_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.init_busy (init_busy),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd),
		.cfg       (cfg)
	);

	llae_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.valid    (q_valid),
		.pop_cmd  (q_cmd)
	);

	llae_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.pop       (pop),
		.init_busy (init_busy),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

/* rtl/llae_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llae_checker: port-level checks of the automaton engine
// Watches the result channel for handshake and field consistency.
// ----------------------------------------------------------------------------
module llae_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input llae_pkg::out_item_t out_data
);
	import llae_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

	// Age is nonzero exactly for a live cell
	a_alive_age: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.alive_out == (out_data.age != '0)))
		else $error("alive flag disagrees with age");

	// Flagged coordinates return no cell
	a_oob_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status |-> !out_data.alive_out)
		else $error("outside-grid transaction returned a live cell");

	// Population never exceeds the grid
	a_pop_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.live_count <= POP_BITS'(CELLS)))
		else $error("population out of range");

endmodule

bind life_like_automaton_engine llae_checker u_llae_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
